>>> hw/rtl/rfidti_pkg.sv
// Shared types, codes and constants of the RFID tag immobilizer.
`default_nettype none

package rfidti_pkg;

    // Sizes of the tag store and the reader frame.
    localparam int NUM_TAGS   = 4;
    localparam int TAG_DIGITS = 16;
    localparam int MAX_DIGITS = 16;
    localparam int TAG_W      = 4 * TAG_DIGITS;
    localparam int COUNT_W    = 5;
    localparam int DIGIT_IDX_W = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOOT_FAILED    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_ZERO       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_ONE        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_TWO        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_THREE      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_TAG_SEC   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_SEC    = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [TAG_W-1:0] TAG_RESET        = '1;
    localparam logic [7:0]       WAIT_TAG_RESET   = 8'd5;
    localparam logic [7:0]       LOCKOUT_RESET    = 8'd180;

    // Fixed countdowns of the machine.
    localparam logic [7:0] CHECK_OLD_SECONDS = 8'd3;
    localparam logic [7:0] ALARM_SECONDS     = 8'd30;

    // Reader framing bytes.
    localparam logic [7:0] CHAR_STX   = 8'h02;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ETX   = 8'h03;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Buzzer commands.
    typedef enum logic [1:0] {
        BZ_NONE = 2'd0,
        BZ_STOP = 2'd1,
        BZ_LONG = 2'd2,
        BZ_BEEP = 2'd3
    } buzzer_t;

    // Immobilizer phases, one-hot.
    typedef enum logic [7:0] {
        PH_INIT         = 8'b0000_0001,
        PH_CHECK_OLD    = 8'b0000_0010,
        PH_WAIT_ON      = 8'b0000_0100,
        PH_WAIT_TAG     = 8'b0000_1000,
        PH_TAG_OK       = 8'b0001_0000,
        PH_TAG_FAIL     = 8'b0010_0000,
        PH_CHECK_MOTION = 8'b0100_0000,
        PH_WAIT_OFF     = 8'b1000_0000
    } phase_t;

    typedef logic [NUM_TAGS-1:0][TAG_W-1:0] tag_array_t;

    // One step as seen by the framer and the machine.
    typedef struct packed {
        logic       fire;
        logic       is_tick;
        logic [7:0] rx_byte;
        logic       ignition_on;
        logic       sms_unlock;
        logic       motion_alarm;
    } step_t;

    // Machine settings taken from the register file.
    typedef struct packed {
        logic       feature_enable;
        logic [7:0] wait_tag_seconds;
        logic [7:0] lockout_seconds;
        logic       boot_load;
        logic       boot_value;
    } immo_cfg_t;

    // Result of one step from the machine.
    typedef struct packed {
        logic       engine_cut;
        logic       reader_enable;
        buzzer_t    buzzer_cmd;
        logic [2:0] phase;
        logic       sms_consumed;
        logic       motion_consumed;
    } immo_res_t;

    // Phase number reported on the result channel.
    function automatic logic [2:0] phase_number(phase_t ph);
        logic [2:0] num;
        case (ph)
            PH_INIT:         num = 3'd0;
            PH_CHECK_OLD:    num = 3'd1;
            PH_WAIT_ON:      num = 3'd2;
            PH_WAIT_TAG:     num = 3'd3;
            PH_TAG_OK:       num = 3'd4;
            PH_TAG_FAIL:     num = 3'd5;
            PH_CHECK_MOTION: num = 3'd6;
            PH_WAIT_OFF:     num = 3'd7;
            default:         num = 3'd0;
        endcase
        return num;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rfidti_if.sv
// Channel interfaces of the RFID tag immobilizer: step input, result output and configuration.
`default_nettype none

interface rfidti_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;
    logic       ignition_on;
    logic       sms_unlock;
    logic       motion_alarm;

    modport source (output valid, func, rx_byte, ignition_on, sms_unlock, motion_alarm,
                    input ready);
    modport sink   (input valid, func, rx_byte, ignition_on, sms_unlock, motion_alarm,
                    output ready);
endinterface

interface rfidti_out_if;
    logic       valid;
    logic       ready;
    logic       engine_cut;
    logic       reader_enable;
    logic [1:0] buzzer_cmd;
    logic [2:0] phase;
    logic       tag_accepted;
    logic       sms_consumed;
    logic       motion_consumed;

    modport source (output valid, engine_cut, reader_enable, buzzer_cmd, phase,
                    tag_accepted, sms_consumed, motion_consumed, input ready);
    modport sink   (input valid, engine_cut, reader_enable, buzzer_cmd, phase,
                    tag_accepted, sms_consumed, motion_consumed, output ready);
endinterface

interface rfidti_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rfidti_pkg::CFG_INDEX_W-1:0] index;
    logic [rfidti_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rfidti_frame.sv
// Reader byte framer with digit buffer and parallel compare against the stored tags.
`default_nettype none

module rfidti_frame (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rfidti_pkg::step_t      step,
    input  wire rfidti_pkg::tag_array_t tags,
    output logic                        tag_match
);

    logic [rfidti_pkg::COUNT_W-1:0] count_reg;
    logic [rfidti_pkg::COUNT_W-1:0] count_next;
    logic [3:0]                     digit_buf_reg [rfidti_pkg::TAG_DIGITS];
    logic                           byte_fire;
    logic                           is_digit;
    logic                           is_term;
    logic [rfidti_pkg::NUM_TAGS-1:0] tag_hit;
    logic [rfidti_pkg::NUM_TAGS-1:0][rfidti_pkg::TAG_DIGITS-1:0] pos_ok;

    assign byte_fire = step.fire && !step.is_tick;

    // Classify the byte.
    always_comb
    begin
        is_term  = step.rx_byte inside {rfidti_pkg::CHAR_CR, rfidti_pkg::CHAR_LF,
                                        rfidti_pkg::CHAR_ETX};
        is_digit = (step.rx_byte >= rfidti_pkg::CHAR_ZERO)
                   && (step.rx_byte <= rfidti_pkg::CHAR_NINE)
                   && (count_reg < rfidti_pkg::COUNT_W'(rfidti_pkg::MAX_DIGITS));
    end

    // Every held digit against every tag; positions past the count always agree.
    always_comb
    begin
        for (int j = 0; j < rfidti_pkg::NUM_TAGS; j++)
        begin
            for (int i = 0; i < rfidti_pkg::TAG_DIGITS; i++)
            begin
                pos_ok[j][i] = (rfidti_pkg::COUNT_W'(i) >= count_reg)
                               || (tags[j][4*i +: 4] == digit_buf_reg[i]);
            end
            tag_hit[j] = &pos_ok[j];
        end
    end

    assign tag_match = byte_fire && is_term && (count_reg != '0) && (|tag_hit);

    // Digit count update.
    always_comb
    begin
        count_next = count_reg;
        if (byte_fire)
        begin
            if (is_digit && (step.rx_byte != rfidti_pkg::CHAR_STX) && !is_term)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Digit store, written at the current count.
    always_ff @(posedge clk)
    begin
        if (byte_fire && is_digit)
        begin
            digit_buf_reg[count_reg[rfidti_pkg::DIGIT_IDX_W-1:0]] <= step.rx_byte[3:0];
        end
    end

    // The count never runs past the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rfidti_pkg::COUNT_W'(rfidti_pkg::MAX_DIGITS))
        else $error("digit count beyond frame limit");

    // A match always clears the frame for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_match |=> (count_reg == '0))
        else $error("frame not cleared after a match");

endmodule

`default_nettype wire

>>> hw/rtl/rfidti_fsm.sv
// Ignition immobilizer machine run on one-second ticks, with tag-seen and fail memory.
`default_nettype none

module rfidti_fsm (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rfidti_pkg::step_t     step,
    input  wire rfidti_pkg::immo_cfg_t cfg,
    input  wire logic                  tag_match,
    output rfidti_pkg::immo_res_t      res
);

    rfidti_pkg::phase_t  phase_reg;
    rfidti_pkg::phase_t  phase_next;
    rfidti_pkg::phase_t  cur_phase;
    logic [7:0]          secs_reg;
    logic [7:0]          secs_next;
    logic                seen_reg;
    logic                seen_next;
    logic                fail_reg;
    logic                fail_next;
    logic                cut_reg;
    logic                cut_next;
    logic                rdr_reg;
    logic                rdr_next;
    rfidti_pkg::buzzer_t buzzer;
    logic                sms_used;
    logic                motion_used;
    logic                run;

    assign run = step.fire && step.is_tick && cfg.feature_enable;

    // Ignition off forces the wait-ignition-on phase before the phase logic.
    assign cur_phase = (!step.ignition_on && (phase_reg != rfidti_pkg::PH_WAIT_ON))
                       ? rfidti_pkg::PH_WAIT_ON : phase_reg;

    // Next state of the machine.
    always_comb
    begin
        phase_next  = phase_reg;
        secs_next   = secs_reg;
        seen_next   = seen_reg;
        fail_next   = fail_reg;
        cut_next    = cut_reg;
        rdr_next    = rdr_reg;
        buzzer      = rfidti_pkg::BZ_NONE;
        sms_used    = 1'b0;
        motion_used = 1'b0;

        if (cfg.boot_load)
        begin
            fail_next = cfg.boot_value;
        end

        if (step.fire && !step.is_tick)
        begin
            if (tag_match)
            begin
                seen_next = 1'b1;
            end
        end
        else if (run)
        begin
            if (secs_reg != '0)
            begin
                secs_next = secs_reg - 8'd1;
            end
            if (cur_phase != phase_reg)
            begin
                phase_next = cur_phase;
                buzzer     = rfidti_pkg::BZ_STOP;
            end

            case (cur_phase)
                rfidti_pkg::PH_INIT:
                begin
                    secs_next  = rfidti_pkg::CHECK_OLD_SECONDS;
                    phase_next = rfidti_pkg::PH_CHECK_OLD;
                end
                rfidti_pkg::PH_CHECK_OLD:
                begin
                    if (secs_next == '0)
                    begin
                        if (step.ignition_on)
                        begin
                            if (fail_reg)
                            begin
                                cut_next   = 1'b1;
                                phase_next = rfidti_pkg::PH_TAG_FAIL;
                                buzzer     = rfidti_pkg::BZ_LONG;
                                secs_next  = rfidti_pkg::ALARM_SECONDS;
                            end
                            else
                            begin
                                phase_next = rfidti_pkg::PH_WAIT_OFF;
                            end
                        end
                        else
                        begin
                            phase_next = rfidti_pkg::PH_WAIT_ON;
                        end
                    end
                end
                rfidti_pkg::PH_WAIT_ON:
                begin
                    if (step.ignition_on)
                    begin
                        seen_next  = 1'b0;
                        cut_next   = 1'b1;
                        rdr_next   = 1'b1;
                        phase_next = rfidti_pkg::PH_WAIT_TAG;
                        secs_next  = cfg.wait_tag_seconds;
                    end
                end
                rfidti_pkg::PH_WAIT_TAG:
                begin
                    if (seen_next || step.sms_unlock)
                    begin
                        sms_used   = 1'b1;
                        seen_next  = 1'b0;
                        rdr_next   = 1'b0;
                        phase_next = rfidti_pkg::PH_TAG_OK;
                    end
                    // A timeout overrides an unlock in the same tick.
                    if (secs_next == '0)
                    begin
                        cut_next   = 1'b1;
                        phase_next = rfidti_pkg::PH_TAG_FAIL;
                        fail_next  = 1'b1;
                        buzzer     = rfidti_pkg::BZ_LONG;
                        secs_next  = cfg.lockout_seconds;
                    end
                end
                rfidti_pkg::PH_TAG_OK:
                begin
                    buzzer     = rfidti_pkg::BZ_BEEP;
                    cut_next   = 1'b0;
                    phase_next = rfidti_pkg::PH_WAIT_OFF;
                    fail_next  = 1'b0;
                end
                rfidti_pkg::PH_TAG_FAIL:
                begin
                    if (secs_next == '0)
                    begin
                        phase_next  = rfidti_pkg::PH_CHECK_MOTION;
                        motion_used = 1'b1;
                        rdr_next    = 1'b0;
                        cut_next    = 1'b0;
                    end
                    if (seen_next || step.sms_unlock)
                    begin
                        seen_next  = 1'b0;
                        rdr_next   = 1'b0;
                        phase_next = rfidti_pkg::PH_TAG_OK;
                    end
                end
                rfidti_pkg::PH_CHECK_MOTION:
                begin
                    if (step.motion_alarm)
                    begin
                        buzzer      = rfidti_pkg::BZ_LONG;
                        seen_next   = 1'b0;
                        rdr_next    = 1'b1;
                        motion_used = 1'b1;
                        cut_next    = 1'b1;
                        phase_next  = rfidti_pkg::PH_TAG_FAIL;
                        secs_next   = rfidti_pkg::ALARM_SECONDS;
                    end
                    if (seen_next || step.sms_unlock)
                    begin
                        sms_used   = 1'b1;
                        seen_next  = 1'b0;
                        rdr_next   = 1'b0;
                        phase_next = rfidti_pkg::PH_TAG_OK;
                    end
                end
                rfidti_pkg::PH_WAIT_OFF:
                begin
                    if (!step.ignition_on)
                    begin
                        phase_next = rfidti_pkg::PH_WAIT_ON;
                        cut_next   = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Machine state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rfidti_pkg::PH_INIT;
            secs_reg  <= '0;
            seen_reg  <= 1'b0;
            fail_reg  <= 1'b0;
            cut_reg   <= 1'b0;
            rdr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            secs_reg  <= secs_next;
            seen_reg  <= seen_next;
            fail_reg  <= fail_next;
            cut_reg   <= cut_next;
            rdr_reg   <= rdr_next;
        end
    end

    // Result of the step, taken by the result register.
    always_comb
    begin
        res.engine_cut      = cut_next;
        res.reader_enable   = rdr_next;
        res.buzzer_cmd      = buzzer;
        res.phase           = rfidti_pkg::phase_number(phase_next);
        res.sms_consumed    = sms_used;
        res.motion_consumed = motion_used;
    end

    // Reader bytes never move the machine.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && !step.is_tick) |=> ($stable(phase_reg) && $stable(secs_reg)
                                          && $stable(cut_reg)))
        else $error("reader byte changed the machine");

    // A tick with the feature off and no boot-failed load changes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && step.is_tick && !cfg.feature_enable && !cfg.boot_load)
        |=> ($stable(phase_reg) && $stable(seen_reg) && $stable(fail_reg)))
        else $error("disabled tick changed the machine");

    // Entering the tag-ok phase always powers the reader down.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rfidti_pkg::PH_TAG_OK) |-> !rdr_reg)
        else $error("reader on in tag-ok phase");

endmodule

`default_nettype wire

>>> hw/rtl/rfidti_cfg_regs.sv
// Configuration register file of the RFID tag immobilizer.
`default_nettype none

module rfidti_cfg_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    rfidti_cfg_if.sink              cfg,
    output rfidti_pkg::tag_array_t  tags,
    output rfidti_pkg::immo_cfg_t   immo_cfg
);

    logic                   feature_enable_reg;
    logic [7:0]             wait_tag_reg;
    logic [7:0]             lockout_reg;
    rfidti_pkg::tag_array_t tags_reg;
    logic                   wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    // Register writes by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_enable_reg <= 1'b0;
            wait_tag_reg       <= rfidti_pkg::WAIT_TAG_RESET;
            lockout_reg        <= rfidti_pkg::LOCKOUT_RESET;
            for (int j = 0; j < rfidti_pkg::NUM_TAGS; j++)
            begin
                tags_reg[j] <= rfidti_pkg::TAG_RESET;
            end
        end
        else if (wr)
        begin
            case (cfg.index)
                rfidti_pkg::REG_FEATURE_ENABLE: feature_enable_reg <= cfg.data[0];
                rfidti_pkg::REG_TAG_ZERO:       tags_reg[0] <= cfg.data;
                rfidti_pkg::REG_TAG_ONE:        tags_reg[1] <= cfg.data;
                rfidti_pkg::REG_TAG_TWO:        tags_reg[2] <= cfg.data;
                rfidti_pkg::REG_TAG_THREE:      tags_reg[3] <= cfg.data;
                rfidti_pkg::REG_WAIT_TAG_SEC:   wait_tag_reg <= cfg.data[7:0];
                rfidti_pkg::REG_LOCKOUT_SEC:    lockout_reg <= cfg.data[7:0];
                default:                        feature_enable_reg <= feature_enable_reg;
            endcase
        end
    end

    // The boot-failed value goes straight into the machine's fail memory.
    always_comb
    begin
        immo_cfg.feature_enable   = feature_enable_reg;
        immo_cfg.wait_tag_seconds = wait_tag_reg;
        immo_cfg.lockout_seconds  = lockout_reg;
        immo_cfg.boot_load        = wr && (cfg.index == rfidti_pkg::REG_BOOT_FAILED);
        immo_cfg.boot_value       = cfg.data[0];
    end

    assign tags = tags_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rfidti_fsm_wrap_note.sv
// Step input register stage of the RFID tag immobilizer.
`default_nettype none

module rfidti_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    rfidti_in_if.sink           req,
    input  wire logic           advance,
    output rfidti_pkg::step_t   step
);

    logic       valid_reg;
    logic       valid_next;
    logic       func_reg;
    logic [7:0] rx_byte_reg;
    logic       ign_reg;
    logic       sms_reg;
    logic       motion_reg;
    logic       take;

    // The stage takes a new transaction whenever it is empty or moving on.
    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds until the next transaction.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg    <= req.func;
            rx_byte_reg <= req.rx_byte;
            ign_reg     <= req.ignition_on;
            sms_reg     <= req.sms_unlock;
            motion_reg  <= req.motion_alarm;
        end
    end

    always_comb
    begin
        step.fire         = valid_reg && advance;
        step.is_tick      = func_reg;
        step.rx_byte      = rx_byte_reg;
        step.ignition_on  = ign_reg;
        step.sms_unlock   = sms_reg;
        step.motion_alarm = motion_reg;
    end

endmodule

`default_nettype wire

>>> hw/rtl/rfid_tag_immobilizer.sv
// Top level of the RFID tag immobilizer.
//
// Usage: each transaction on req is one step, either a reader byte (func 0)
// or a one-second tick (func 1). Every step gives exactly one transaction on
// rsp with the engine-cut and reader-enable levels, the buzzer command, the
// phase number, and the tag-accepted and consumed flags.
// The cfg channel writes the eight registers by index; it is always ready and
// should only be used while no step is in flight.
// A step waits in the input register and passes through the framer and
// machine into the result register, which drives rsp.
// Throughput is one step per cycle while rsp does not stall; the machine and
// the framer update their state as each step fires.
// Reset clears the machine to its init phase, empties the frame, and loads the
// register reset values (all tags unused, five-second tag wait, 180-second
// lockout, feature off).
// When rsp stalls, the result register holds and one more step is taken into
// the input register; req then drops ready until rsp moves.
`default_nettype none

module rfid_tag_immobilizer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rfidti_in_if.sink   req,
    rfidti_out_if.source rsp,
    rfidti_cfg_if.sink  cfg
);

    rfidti_pkg::step_t      step;
    rfidti_pkg::tag_array_t tags;
    rfidti_pkg::immo_cfg_t  immo_cfg;
    rfidti_pkg::immo_res_t  res;
    logic                   tag_match;
    logic                   advance;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rfidti_pkg::immo_res_t  res_reg;
    logic                   accepted_reg;

    // The result register frees up when empty or taken.
    assign advance = !out_valid_reg || rsp.ready;

    rfidti_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .tags     (tags),
        .immo_cfg (immo_cfg)
    );

    rfidti_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .step    (step)
    );

    rfidti_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .tags      (tags),
        .tag_match (tag_match)
    );

    rfidti_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cfg       (immo_cfg),
        .tag_match (tag_match),
        .res       (res)
    );

    // Result register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (step.fire)
        begin
            res_reg      <= res;
            accepted_reg <= tag_match;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.engine_cut      = res_reg.engine_cut;
    assign rsp.reader_enable   = res_reg.reader_enable;
    assign rsp.buzzer_cmd      = res_reg.buzzer_cmd;
    assign rsp.phase           = res_reg.phase;
    assign rsp.tag_accepted    = accepted_reg;
    assign rsp.sms_consumed    = res_reg.sms_consumed;
    assign rsp.motion_consumed = res_reg.motion_consumed;

    // A step that accepts a tag never also issues machine actions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.tag_accepted)
        |-> (rsp.buzzer_cmd == rfidti_pkg::BZ_NONE && !rsp.sms_consumed
             && !rsp.motion_consumed))
        else $error("tag accepted on a machine step");

    // A step can only complete into a free result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        step.fire |-> (!out_valid_reg || rsp.ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire
